FILE: rtl/lru_page_order_list_assert.svh
// Assertion macros used by the checker of the page order list.
`ifndef LRU_PAGE_ORDER_LIST_ASSERT_SVH
`define LRU_PAGE_ORDER_LIST_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPOL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpol assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LPOL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpol assertion failed");

`endif

FILE: rtl/lpol_pkg.sv
// Package with the constants, codes and types of the page order list.
`timescale 1ns / 1ps
package lpol_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  localparam logic [2:0] MODE_INSERT = 3'd0;
  localparam logic [2:0] MODE_EVICT  = 3'd1;
  localparam logic [2:0] MODE_TOUCH  = 3'd2;
  localparam logic [2:0] MODE_FREE   = 3'd3;
  localparam logic [2:0] MODE_QUERY  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_MARK_HEAD,
    OP_MARK_PAGE,
    OP_MARK_PROC,
    OP_SHIFT,
    OP_TOUCH_SHIFT
  } cell_op_t;

  typedef struct packed {
    logic        valid;
    logic        flag;
    logic [15:0] page;
    logic [7:0]  process;
    logic [7:0]  frame;
  } entry_t;

  typedef struct packed {
    cell_op_t    op;
    logic [15:0] page;
    logic [7:0]  process;
    logic [7:0]  frame;
  } cell_cmd_t;

endpackage

FILE: rtl/lpol_if.sv
// Valid/ready channel interfaces for operations and results.
`timescale 1ns / 1ps
interface lpol_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [15:0] page_number;
  logic [7:0]  process_number;
  logic [7:0]  frame_number;

  modport source (output valid, output mode, output page_number,
                  output process_number, output frame_number, input ready);
  modport sink (input valid, input mode, input page_number,
                input process_number, input frame_number, output ready);
endinterface

interface lpol_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] oldest_page;
  logic [7:0]  oldest_process;
  logic [7:0]  oldest_frame;
  logic [4:0]  entry_count;
  logic        is_empty;
  logic        touch_hit;
  logic [1:0]  status;

  modport source (output valid, output oldest_page, output oldest_process,
                  output oldest_frame, output entry_count, output is_empty,
                  output touch_hit, output status, input ready);
  modport sink (input valid, input oldest_page, input oldest_process,
                input oldest_frame, input entry_count, input is_empty,
                input touch_hit, input status, output ready);
endinterface

FILE: rtl/lpol_cell.sv
// One slot of the list: holds an entry and moves it toward the head on removal.
`timescale 1ns / 1ps
module lpol_cell import lpol_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_cmd_t cmd,
  input  logic      is_head,
  input  logic      left_valid,
  input  logic      left_past,
  input  entry_t    carry_in,
  input  entry_t    right_ent,
  output entry_t    ent,
  output logic      past_out,
  output entry_t    carry_out
);

  entry_t ent_r;
  entry_t ent_nxt;
  logic   marked;
  logic   is_last;

  // A marked cell with no marked cell to its left is the first one; it
  // places its entry on the carry line for the tail cell.
  assign marked    = ent_r.valid & ent_r.flag;
  assign past_out  = left_past | marked;
  assign carry_out = (marked && !left_past) ? ent_r : carry_in;
  assign is_last   = ent_r.valid & ~right_ent.valid;
  assign ent       = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    case (cmd.op)
      OP_INSERT: begin
        if (!ent_r.valid && (is_head || left_valid)) begin
          ent_nxt.valid   = 1'b1;
          ent_nxt.flag    = 1'b0;
          ent_nxt.page    = cmd.page;
          ent_nxt.process = cmd.process;
          ent_nxt.frame   = cmd.frame;
        end
      end
      OP_MARK_HEAD: ent_nxt.flag = ent_r.valid & is_head;
      OP_MARK_PAGE: ent_nxt.flag = ent_r.valid & (ent_r.page == cmd.page);
      OP_MARK_PROC: ent_nxt.flag = ent_r.valid & (ent_r.process == cmd.process);
      OP_SHIFT: begin
        if (past_out) begin
          ent_nxt = right_ent;
        end
      end
      OP_TOUCH_SHIFT: begin
        if (past_out) begin
          if (is_last) begin
            ent_nxt       = carry_out;
            ent_nxt.valid = 1'b1;
          end else begin
            ent_nxt = right_ent;
          end
        end
        ent_nxt.flag = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
      ent_r.flag  <= 1'b0;
    end else begin
      ent_r.valid <= ent_nxt.valid;
      ent_r.flag  <= ent_nxt.flag;
    end
    ent_r.page    <= ent_nxt.page;
    ent_r.process <= ent_nxt.process;
    ent_r.frame   <= ent_nxt.frame;
  end

endmodule

FILE: rtl/lru_page_order_list.sv
// Top level of the page order list: cell chain, sequencer and result register.
`timescale 1ns / 1ps
// The list keeps up to MAX_ENTRIES resident pages in a row of cells, oldest in
// cell 0, newest in the last valid cell. One input transaction carries one
// operation and yields exactly one result transaction, which reports the oldest
// entry, the count, an empty flag, the touch hit flag and a status. Insert,
// query, and a refused insert or evict go straight from idle to the finish
// state, where the result is registered; evict and touch pass through the step
// state once, and free stays in it until no entry is marked. Removal moves
// every entry to the right of the removed one a single cell toward the head, so
// a free removes its matching entries one at a time. A new operation is
// accepted in the cycle after its predecessor's result is registered, even
// while that result still waits at the output; the result register only holds
// the sequencer back when a second result is ready before the first was taken.
module lru_page_order_list import lpol_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  lpol_in_if.sink    in_ch,
  lpol_out_if.source out_ch
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_FINISH
  } state_t;

  state_t           state_r;
  logic [2:0]       mode_r;
  logic [1:0]       status_r;
  logic             hit_r;
  logic [CNT_W-1:0] count_r;

  logic             out_valid_r;
  logic [15:0]      out_page_r;
  logic [7:0]       out_process_r;
  logic [7:0]       out_frame_r;
  logic [4:0]       out_count_r;
  logic             out_empty_r;
  logic             out_hit_r;
  logic [1:0]       out_status_r;

  cell_cmd_t cmd;
  logic      accept;
  logic      full;
  logic      empty;
  logic      any_marked;
  logic      out_free;
  logic [31:0] count_ext;

  // Chain signals between neighboring cells.
  entry_t ents     [MAX_ENTRIES];
  logic   past     [MAX_ENTRIES];
  entry_t carry    [MAX_ENTRIES];
  entry_t carry_w  [MAX_ENTRIES];
  entry_t right_w  [MAX_ENTRIES];
  logic   lvalid_w [MAX_ENTRIES];
  logic   lpast_w  [MAX_ENTRIES];

  assign accept     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign full       = (count_r == CNT_W'(MAX_ENTRIES));
  assign empty      = (count_r == '0);
  // The last cell's prefix output tells whether any cell is still marked.
  assign any_marked = past[MAX_ENTRIES-1];
  assign out_free   = !out_valid_r || out_ch.ready;
  assign count_ext  = 32'(count_r);

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign lvalid_w[i] = 1'b0;
      assign lpast_w[i]  = 1'b0;
      assign carry_w[i]  = '0;
    end else begin : g_body
      assign lvalid_w[i] = ents[i-1].valid;
      assign lpast_w[i]  = past[i-1];
      assign carry_w[i]  = carry[i-1];
    end
    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign right_w[i] = '0;
    end else begin : g_inner
      assign right_w[i] = ents[i+1];
    end

    lpol_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .is_head   (i == 0),
      .left_valid(lvalid_w[i]),
      .left_past (lpast_w[i]),
      .carry_in  (carry_w[i]),
      .right_ent (right_w[i]),
      .ent       (ents[i]),
      .past_out  (past[i]),
      .carry_out (carry[i])
    );
  end

  // Command broadcast to all cells. On acceptance the cells insert or mark
  // directly from the input payload; in the step state the first marked entry is
  // removed, or on a touch moved to the newest end.
  always_comb begin
    cmd.op      = OP_NONE;
    cmd.page    = in_ch.page_number;
    cmd.process = in_ch.process_number;
    cmd.frame   = in_ch.frame_number;
    if (state_r == S_IDLE && accept) begin
      case (in_ch.mode)
        MODE_INSERT: cmd.op = full ? OP_NONE : OP_INSERT;
        MODE_EVICT:  cmd.op = empty ? OP_NONE : OP_MARK_HEAD;
        MODE_TOUCH:  cmd.op = OP_MARK_PAGE;
        MODE_FREE:   cmd.op = OP_MARK_PROC;
        default:     cmd.op = OP_NONE;
      endcase
    end else if (state_r == S_STEP) begin
      cmd.op = (mode_r == MODE_TOUCH) ? OP_TOUCH_SHIFT : OP_SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // In the finish state the result register is loaded below instead.
      if (out_valid_r && out_ch.ready && state_r != S_FINISH) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            mode_r <= in_ch.mode;
            hit_r  <= 1'b0;
            case (in_ch.mode)
              MODE_INSERT: begin
                state_r <= S_FINISH;
                if (full) begin
                  status_r <= ST_FULL;
                end else begin
                  status_r <= ST_OK;
                  count_r  <= count_r + CNT_W'(1);
                end
              end
              MODE_EVICT: begin
                if (empty) begin
                  status_r <= ST_EMPTY;
                  state_r  <= S_FINISH;
                end else begin
                  status_r <= ST_OK;
                  state_r  <= S_STEP;
                end
              end
              MODE_TOUCH, MODE_FREE: begin
                status_r <= ST_OK;
                state_r  <= S_STEP;
              end
              default: begin
                status_r <= ST_OK;
                state_r  <= S_FINISH;
              end
            endcase
          end
        end
        S_STEP: begin
          if (mode_r == MODE_TOUCH) begin
            hit_r   <= any_marked;
            state_r <= S_FINISH;
          end else if (mode_r == MODE_EVICT) begin
            count_r <= count_r - CNT_W'(1);
            state_r <= S_FINISH;
          end else if (any_marked) begin
            // Free: one matching entry leaves the list in this cycle.
            count_r <= count_r - CNT_W'(1);
          end else begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_page_r    <= ents[0].valid ? ents[0].page : 16'd0;
            out_process_r <= ents[0].valid ? ents[0].process : 8'd0;
            out_frame_r   <= ents[0].valid ? ents[0].frame : 8'd0;
            out_count_r   <= count_ext[4:0];
            out_empty_r   <= empty;
            out_hit_r     <= hit_r;
            out_status_r  <= status_r;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.oldest_page    = out_page_r;
  assign out_ch.oldest_process = out_process_r;
  assign out_ch.oldest_frame   = out_frame_r;
  assign out_ch.entry_count    = out_count_r;
  assign out_ch.is_empty       = out_empty_r;
  assign out_ch.touch_hit      = out_hit_r;
  assign out_ch.status         = out_status_r;

endmodule

FILE: rtl/lpol_checker.sv
// Port-level assertions for the page order list, bound to its top level.
`timescale 1ns / 1ps
`include "lru_page_order_list_assert.svh"
module lpol_checker import lpol_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] oldest_page,
  input logic [4:0]  entry_count,
  input logic        is_empty,
  input logic        touch_hit,
  input logic [1:0]  status
);

  // A stalled result keeps its contents until it is taken.
  `LPOL_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(oldest_page) && $stable(entry_count) && $stable(status))

  // An empty list reports a zero count and a cleared oldest entry.
  `LPOL_ASSERT_IMP(a_empty_fields, clk, rst_n, out_valid && is_empty, entry_count == 5'd0 && oldest_page == 16'd0)

  // A touch hit means the list held the page and the operation succeeded.
  `LPOL_ASSERT_IMP(a_hit_ok, clk, rst_n, out_valid && touch_hit, !is_empty && status == ST_OK)

  // The count never exceeds the capacity and the status code is defined.
  `LPOL_ASSERT_IMP(a_count_status, clk, rst_n, out_valid, 32'(entry_count) <= MAX_ENTRIES && status != 2'd3)

endmodule

bind lru_page_order_list lpol_checker u_lpol_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .oldest_page(out_ch.oldest_page),
  .entry_count(out_ch.entry_count),
  .is_empty   (out_ch.is_empty),
  .touch_hit  (out_ch.touch_hit),
  .status     (out_ch.status)
);

FILE: tb/tb_lru_page_order_list.sv
// Self-checking testbench for the LRU page order list.
`timescale 1ns / 1ps
module tb_lru_page_order_list;
  import lpol_pkg::*;

  // The unused mode codes behave as a query.
  localparam logic [2:0] MODE_SPARE_5 = 3'd5;
  localparam logic [2:0] MODE_SPARE_6 = 3'd6;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;

  localparam int IDLE_PCT     = 31;
  localparam int RANDOM_ITEMS = 1450;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 40;

  typedef struct packed {
    logic [15:0] page;
    logic [7:0]  process;
    logic [7:0]  frame;
  } resident_t;

  typedef struct packed {
    logic [15:0] oldest_page;
    logic [7:0]  oldest_process;
    logic [7:0]  oldest_frame;
    logic [4:0]  entry_count;
    logic        is_empty;
    logic        touch_hit;
    logic [1:0]  status;
  } list_report_t;

  logic clk = 1'b0;
  logic rst_n;

  lpol_in_if  in_if ();
  lpol_out_if out_if ();

  lru_page_order_list i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #4 clk = ~clk;

  // Shadow copy of the list, oldest entry in slot 0.
  resident_t    shadow_slots [MAX_ENTRIES];
  int           shadow_count;
  list_report_t expected_reports [$];

  bit sender_idle_on;
  bit receiver_idle_on;
  int receiver_hold_left;

  int mismatches;
  int unexpected_reports;
  int reports_checked;
  int ops_by_mode [8];
  int touch_hits;
  int full_refusals;
  int empty_evicts;
  int peak_fill;

  // Closes the gap left by removing the entry at pos and clears the freed slot.
  function automatic void drop_slot(input int pos);
    for (int i = pos; i + 1 < shadow_count; i++) begin
      shadow_slots[i] = shadow_slots[i + 1];
    end
    shadow_count--;
    shadow_slots[shadow_count] = '0;
  endfunction

  // Applies one operation to the shadow list and returns the report it yields.
  function automatic list_report_t predict_lru_step(input logic [2:0] mode,
                                                    input logic [15:0] page,
                                                    input logic [7:0] proc,
                                                    input logic [7:0] frame);
    list_report_t rep;
    resident_t    moved;
    int           idx;
    rep = '0;
    rep.status = ST_OK;
    case (mode)
      MODE_INSERT: begin
        if (shadow_count >= MAX_ENTRIES) begin
          rep.status = ST_FULL;
        end else begin
          shadow_slots[shadow_count] = '{page: page, process: proc, frame: frame};
          shadow_count++;
        end
      end
      MODE_EVICT: begin
        if (shadow_count == 0) rep.status = ST_EMPTY;
        else drop_slot(0);
      end
      MODE_TOUCH: begin
        // Only the first entry with a matching page moves to the newest end.
        for (idx = 0; idx < shadow_count; idx++) begin
          if (shadow_slots[idx].page == page) begin
            moved = shadow_slots[idx];
            drop_slot(idx);
            shadow_slots[shadow_count] = moved;
            shadow_count++;
            rep.touch_hit = 1'b1;
            break;
          end
        end
      end
      MODE_FREE: begin
        idx = 0;
        while (idx < shadow_count) begin
          if (shadow_slots[idx].process == proc) drop_slot(idx);
          else idx++;
        end
      end
      default: begin
      end
    endcase
    if (shadow_count > 0) begin
      rep.oldest_page    = shadow_slots[0].page;
      rep.oldest_process = shadow_slots[0].process;
      rep.oldest_frame   = shadow_slots[0].frame;
    end
    rep.entry_count = shadow_count[4:0];
    rep.is_empty    = (shadow_count == 0);
    return rep;
  endfunction

  // Offers one operation and waits for the accepting edge. Valid stays high
  // afterwards, so back-to-back transactions lower it in between only for random idling.
  task automatic send_op(input logic [2:0] mode, input logic [15:0] page,
                         input logic [7:0] proc, input logic [7:0] frame);
    list_report_t rep;
    @(negedge clk);
    while (sender_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.mode           <= mode;
    in_if.page_number    <= page;
    in_if.process_number <= proc;
    in_if.frame_number   <= frame;
    do @(posedge clk); while (!in_if.ready);
    rep = predict_lru_step(mode, page, proc, frame);
    expected_reports.push_back(rep);
    ops_by_mode[mode]++;
    if (rep.touch_hit) touch_hits++;
    if (rep.status == ST_FULL) full_refusals++;
    if (rep.status == ST_EMPTY) empty_evicts++;
    if (shadow_count > peak_fill) peak_fill = shadow_count;
  endtask

  // Drops valid and waits until every expected report has arrived or the drain limit runs out.
  task automatic wait_for_reports();
    int waited;
    waited = 0;
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_reports.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // Result checker: every accepted report is matched with the oldest prediction.
  always @(posedge clk) begin
    list_report_t got;
    list_report_t exp;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.oldest_page    = out_if.oldest_page;
      got.oldest_process = out_if.oldest_process;
      got.oldest_frame   = out_if.oldest_frame;
      got.entry_count    = out_if.entry_count;
      got.is_empty       = out_if.is_empty;
      got.touch_hit      = out_if.touch_hit;
      got.status         = out_if.status;
      if (expected_reports.size() == 0) begin
        unexpected_reports++;
        $display("unexpected report: page %h proc %h frame %h count %0d", got.oldest_page,
                 got.oldest_process, got.oldest_frame, got.entry_count);
      end else begin
        exp = expected_reports.pop_front();
        reports_checked++;
        if (got.oldest_page !== exp.oldest_page || got.oldest_process !== exp.oldest_process ||
            got.oldest_frame !== exp.oldest_frame || got.entry_count !== exp.entry_count ||
            got.is_empty !== exp.is_empty || got.touch_hit !== exp.touch_hit ||
            got.status !== exp.status) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch %0d at report %0d:", mismatches, reports_checked);
            $display("  expected page %h proc %h frame %h count %0d empty %b hit %b st %0d",
                     exp.oldest_page, exp.oldest_process, exp.oldest_frame, exp.entry_count,
                     exp.is_empty, exp.touch_hit, exp.status);
            $display("  actual   page %h proc %h frame %h count %0d empty %b hit %b st %0d",
                     got.oldest_page, got.oldest_process, got.oldest_frame, got.entry_count,
                     got.is_empty, got.touch_hit, got.status);
          end
        end
      end
    end
  end

  // Result receiver: a requested hold-off wins, otherwise random idling.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (receiver_hold_left > 0) begin
        out_if.ready <= 1'b0;
        receiver_hold_left--;
      end else if (receiver_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Every mode but insert on an empty list, including the refused evict.
  task automatic test_empty_list();
    send_op(MODE_QUERY, 16'h0000, 8'h00, 8'h00);
    send_op(MODE_EVICT, 16'hFFFF, 8'hFF, 8'hFF);
    send_op(MODE_TOUCH, 16'h0000, 8'h00, 8'h00);
    send_op(MODE_FREE, 16'h0000, 8'h00, 8'h00);
    send_op(MODE_SPARE_7, 16'hFFFF, 8'hFF, 8'hFF);
  endtask

  // Touching the only entry must keep it in the list.
  task automatic test_single_entry();
    send_op(MODE_INSERT, 16'hFFFF, 8'hFF, 8'hFF);
    send_op(MODE_TOUCH, 16'hFFFF, 8'h00, 8'h00);
    send_op(MODE_EVICT, 16'h0000, 8'h00, 8'h00);
  endtask

  // Fill to capacity, overflow, then touch and free at both ends of the list.
  task automatic test_full_list();
    logic [15:0] pg;
    logic [7:0]  pr;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      // Page zero appears twice; the free below takes out the first copy before the touch.
      pg = (i == 0 || i == 5) ? 16'h0000 : (i == 15) ? 16'hFFFF : 16'(i * 16'h1001);
      pr = (i % 3 == 0) ? 8'hAA : (i == 1) ? 8'h00 : (i == 14) ? 8'hFF : 8'(i);
      send_op(MODE_INSERT, pg, pr, 8'(i * 17));
    end
    send_op(MODE_INSERT, 16'hBEEF, 8'h12, 8'h34);
    send_op(MODE_TOUCH, 16'hFFFF, 8'h00, 8'h00);
    // The head and the newest entry both belong to this process.
    send_op(MODE_FREE, 16'h0000, 8'hAA, 8'h00);
    send_op(MODE_TOUCH, 16'h0000, 8'h00, 8'h00);
    send_op(MODE_TOUCH, 16'h4321, 8'h00, 8'h00);
    send_op(MODE_SPARE_5, 16'h5555, 8'h55, 8'h55);
    send_op(MODE_SPARE_6, 16'hAAAA, 8'hAA, 8'hAA);
    send_op(MODE_EVICT, 16'h0000, 8'h00, 8'h00);
    wait_for_reports();
  endtask

  // The receiver holds off while the sender keeps offering, so input stalls.
  task automatic test_output_stall();
    sender_idle_on = 1'b0;
    send_op(MODE_QUERY, 16'h0000, 8'h00, 8'h00);
    receiver_hold_left = 300;
    for (int i = 0; i < 24; i++) begin
      send_op((i % 4 == 3) ? MODE_TOUCH : MODE_INSERT, 16'($urandom), 8'($urandom),
              8'($urandom));
    end
    sender_idle_on = 1'b1;
    wait_for_reports();
  endtask

  // Mostly well-formed traffic: touches and frees aimed at resident entries,
  // with phases that drive the list toward full and toward empty.
  task automatic test_random_traffic();
    logic [15:0] page_pool [16];
    logic [7:0]  proc_pool [6];
    logic [2:0]  mode;
    logic [15:0] pg;
    logic [7:0]  pr;
    int          roll;
    int          insert_pct;
    for (int i = 0; i < 16; i++) page_pool[i] = 16'($urandom);
    page_pool[0] = 16'h0000;
    page_pool[1] = 16'hFFFF;
    for (int i = 0; i < 6; i++) proc_pool[i] = 8'($urandom);
    proc_pool[0] = 8'h00;
    proc_pool[1] = 8'hFF;
    insert_pct = 40;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 120 == 0) insert_pct = $urandom_range(15, 65);
      // A long stretch in the middle runs with no idling on either side.
      if (n == 500) begin
        sender_idle_on = 1'b0;
        receiver_idle_on = 1'b0;
      end
      if (n == 800) begin
        sender_idle_on = 1'b1;
        receiver_idle_on = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < insert_pct) mode = MODE_INSERT;
      else if (roll < insert_pct + 10) mode = MODE_EVICT;
      else if (roll < 82) mode = MODE_TOUCH;
      else if (roll < 90) mode = MODE_FREE;
      else if (roll < 96) mode = MODE_QUERY;
      else mode = 3'($urandom_range(MODE_SPARE_5, MODE_SPARE_7));
      pg = ($urandom_range(0, 99) < 80) ? page_pool[$urandom_range(0, 15)] : 16'($urandom);
      pr = ($urandom_range(0, 99) < 80) ? proc_pool[$urandom_range(0, 5)] : 8'($urandom);
      if (shadow_count > 0 && $urandom_range(0, 99) < 60) begin
        if (mode == MODE_TOUCH) pg = shadow_slots[$urandom_range(0, shadow_count - 1)].page;
        if (mode == MODE_FREE) pr = shadow_slots[$urandom_range(0, shadow_count - 1)].process;
      end
      send_op(mode, pg, pr, 8'($urandom));
    end
    wait_for_reports();
  endtask

  initial begin
    rst_n                = 1'b0;
    in_if.valid          = 1'b0;
    in_if.mode           = MODE_QUERY;
    in_if.page_number    = '0;
    in_if.process_number = '0;
    in_if.frame_number   = '0;
    sender_idle_on       = 1'b1;
    receiver_idle_on     = 1'b1;
    receiver_hold_left   = 0;
    mismatches           = 0;
    unexpected_reports   = 0;
    reports_checked      = 0;
    touch_hits           = 0;
    full_refusals        = 0;
    empty_evicts         = 0;
    peak_fill            = 0;
    shadow_count         = 0;
    for (int i = 0; i < 8; i++) ops_by_mode[i] = 0;
    for (int i = 0; i < MAX_ENTRIES; i++) shadow_slots[i] = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_single_entry();
    test_full_list();
    test_output_stall();
    test_random_traffic();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_reports.size() != 0) begin
      $display("%0d predicted reports never arrived", expected_reports.size());
    end
    $display("checked %0d reports: %0d inserts, %0d evicts, %0d touches, %0d frees, %0d queries",
             reports_checked, ops_by_mode[MODE_INSERT], ops_by_mode[MODE_EVICT],
             ops_by_mode[MODE_TOUCH], ops_by_mode[MODE_FREE],
             ops_by_mode[MODE_QUERY] + ops_by_mode[MODE_SPARE_5] +
             ops_by_mode[MODE_SPARE_6] + ops_by_mode[MODE_SPARE_7]);
    $display("touch hits %0d, full refusals %0d, empty evicts %0d, peak fill %0d, mismatches %0d",
             touch_hits, full_refusals, empty_evicts, peak_fill, mismatches);
    if (mismatches == 0 && unexpected_reports == 0 && expected_reports.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("timeout with %0d reports outstanding", expected_reports.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/lpol_pkg.sv
rtl/lpol_if.sv
rtl/lpol_cell.sv
rtl/lru_page_order_list.sv
rtl/lpol_checker.sv
tb/tb_lru_page_order_list.sv
